@@ rtl/wbps_pkg.sv @@
`timescale 1ns / 1ps

package wbps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PATTERN_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // Pattern register file geometry
  localparam int PAT_BYTES = 32;
  localparam int PAT_BITS  = PAT_BYTES * 8;
  localparam int LEN_W     = 6;
  localparam int OUT_OFF_W = 32;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;

  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_PAT_A = 3'd0;
  localparam logic [2:0] REG_PAT_B = 3'd1;
  localparam logic [2:0] REG_PAT_C = 3'd2;
  localparam logic [2:0] REG_PAT_D = 3'd3;
  localparam logic [2:0] REG_LEN   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_beat_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] match_offset;
  } out_beat_t;

  // Pattern view handed to every cell
  typedef struct packed {
    logic [PAT_BITS-1:0] bytes;
    logic [LEN_W-1:0]    len;
  } pat_cfg_t;

  // Clamp the raw length register to 1..cap
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw,
                                               input logic [LEN_W-1:0] cap);
    logic [LEN_W-1:0] l;
    l = (raw == '0) ? LEN_W'(1) : raw;
    if (l > cap) l = cap;
    return l;
  endfunction

endpackage

@@ rtl/wbps_regs.sv @@
`timescale 1ns / 1ps

module wbps_regs #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbps_pkg::CFG_AW-1:0]  paddr,
  input  logic [wbps_pkg::CFG_DW-1:0]  pwdata,
  output logic [wbps_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output wbps_pkg::pat_cfg_t           pat_cfg
);
  import wbps_pkg::*;

  localparam int CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

  logic [CFG_DW-1:0] pat_a_r, pat_b_r, pat_c_r, pat_d_r;
  logic [LEN_W-1:0]  len_r;
  logic [2:0]        idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:3];
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_a_r <= '0;
      pat_b_r <= '0;
      pat_c_r <= '0;
      pat_d_r <= '0;
      len_r   <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_A: pat_a_r <= pwdata;
        REG_PAT_B: pat_b_r <= pwdata;
        REG_PAT_C: pat_c_r <= pwdata;
        REG_PAT_D: pat_d_r <= pwdata;
        REG_LEN:   len_r   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_PAT_A: prdata = pat_a_r;
      REG_PAT_B: prdata = pat_b_r;
      REG_PAT_C: prdata = pat_c_r;
      REG_PAT_D: prdata = pat_d_r;
      REG_LEN:   prdata = {{(CFG_DW-LEN_W){1'b0}}, len_r};
      default:   prdata = '0;
    endcase
  end

  assign pat_cfg.bytes = {pat_d_r, pat_c_r, pat_b_r, pat_a_r};
  assign pat_cfg.len   = eff_len(len_r, LEN_W'(CAP));

endmodule

@@ rtl/wbps_cell.sv @@
`timescale 1ns / 1ps

module wbps_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               shift,
  input  logic [7:0]         byte_in,
  input  wbps_pkg::pat_cfg_t pat_cfg,
  output logic [7:0]         byte_r,
  output logic               hit
);
  import wbps_pkg::*;

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

  logic             in_use;
  logic             edge_pos;
  logic [LEN_W-1:0] pidx;
  logic [7:0]       pat_byte;

  // Window entry IDX pairs with pattern byte len-1-IDX
  assign in_use   = IDX_L < pat_cfg.len;
  assign pidx     = pat_cfg.len - LEN_W'(1) - IDX_L;
  assign edge_pos = (IDX_L == '0) || (pidx == '0);
  assign pat_byte = pat_cfg.bytes[pidx[4:0]*8 +: 8];

  // Compare the byte this cell takes on this beat
  assign hit = !in_use || (byte_in == pat_byte) ||
               (!edge_pos && (pat_byte == WILDCARD_BYTE));

  // Entries beyond the pattern length are never compared, so no reset is needed
  always_ff @(posedge clk) begin
    if (shift) byte_r <= byte_in;
  end

endmodule

@@ rtl/wildcard_byte_pattern_search_core.sv @@
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after the input beat that causes it.
// Throughput: one byte per cycle while the output is not stalled; all window cells compare in parallel each beat.
// The output register accepts a new result while the current one is taken.
// Reset (rst_n low, synchronous): pattern registers to zero, length to one,
// byte count and match flag cleared, output empty.
module wildcard_byte_pattern_search_core #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wbps_pkg::in_beat_t           in_beat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wbps_pkg::out_beat_t          out_beat,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wbps_pkg::CFG_AW-1:0]  paddr,
  input  logic [wbps_pkg::CFG_DW-1:0]  pwdata,
  output logic [wbps_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import wbps_pkg::*;

  pat_cfg_t                pat_cfg;
  logic [7:0]              win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  hit;
  logic [OFFSET_BITS-1:0]  count_r, count_nxt, count_inc, len_ext, start;
  logic                    reported_r, reported_nxt;
  logic                    out_valid_r;
  out_beat_t               out_beat_r;
  logic                    acc, active, shift, match_now, emit;

  wbps_regs #(.MAX_PATTERN(MAX_PATTERN)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pat_cfg (pat_cfg)
  );

  // Window: a row of cells, entry 0 holds the newest byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] b_in;
    if (k == 0) begin : g_head
      assign b_in = in_beat.data_byte;
    end else begin : g_link
      assign b_in = win[k-1];
    end
    wbps_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .shift   (shift),
      .byte_in (b_in),
      .pat_cfg (pat_cfg),
      .byte_r  (win[k]),
      .hit     (hit[k])
    );
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign active    = !reported_r && (count_r != '1);
  assign shift     = acc && active;
  assign count_inc = count_r + OFFSET_BITS'(1);
  assign len_ext   = OFFSET_BITS'(pat_cfg.len);
  assign start     = count_inc - len_ext;
  assign match_now = active && (count_inc >= len_ext) && (&hit);
  assign emit      = acc && (match_now || (in_beat.region_end && !reported_r));

  // Advance the byte count; drop region state at the last byte
  always_comb begin
    count_nxt    = count_r;
    reported_nxt = reported_r;
    if (acc) begin
      if (in_beat.region_end) begin
        count_nxt    = '0;
        reported_nxt = 1'b0;
      end else if (active) begin
        count_nxt    = count_inc;
        reported_nxt = match_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      reported_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      reported_r <= reported_nxt;
    end
  end

  // Output register: load a result, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r.found        <= match_now;
      out_beat_r.match_offset <= match_now ? OUT_OFF_W'(start) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

@@ rtl/wbps_checker.sv @@
`timescale 1ns / 1ps

module wbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input wbps_pkg::out_beat_t out_beat
);
  import wbps_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result changed while stalled");

  // A not-found result carries offset zero
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.found |-> out_beat.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // Take input whenever the output stage is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Accept input while a result drains
  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while result drains");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind wildcard_byte_pattern_search_core wbps_checker u_wbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_beat  (out_beat)
);
